FILE: sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define JCLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, held off during reset
`define JCLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: sv/jcle_pkg.sv
// shared types and widths of the joystick chord letter encoder
package jcle_pkg;

    localparam int HOLD_W = 16;
    localparam int CODE_W = 8;

    // one contact sample, 1 released, 0 pressed
    typedef struct packed {
        logic up_released;
        logic right_released;
        logic down_released;
        logic left_released;
    } sample_t;

    // one result request
    typedef struct packed {
        logic              letter_valid;
        logic [CODE_W-1:0] letter_code;
        logic              delete_last;
        logic              red_lamp;
        logic              green_lamp;
    } result_t;

    // encoder state carried from tick to tick
    typedef struct packed {
        logic              consonant_group;
        logic              armed;
        logic              finished;
        logic              holding;
        logic [HOLD_W-1:0] hold_count;
        logic              red_on;
        logic              green_on;
    } state_t;

endpackage

FILE: sv/jcle_if.sv
// handshake channel interfaces of the joystick chord letter encoder

// contact sample channel
interface jcle_sample_if;
    logic valid;
    logic ready;
    logic up_released;
    logic right_released;
    logic down_released;
    logic left_released;

    modport source (output valid, output up_released, output right_released,
                    output down_released, output left_released, input ready);
    modport sink (input valid, input up_released, input right_released,
                  input down_released, input left_released, output ready);
endinterface

// result channel
interface jcle_result_if;
    logic                          valid;
    logic                          ready;
    logic                          letter_valid;
    logic [jcle_pkg::CODE_W-1:0]   letter_code;
    logic                          delete_last;
    logic                          red_lamp;
    logic                          green_lamp;

    modport source (output valid, output letter_valid, output letter_code,
                    output delete_last, output red_lamp, output green_lamp, input ready);
    modport sink (input valid, input letter_valid, input letter_code,
                  input delete_last, input red_lamp, input green_lamp, output ready);
endinterface

// hold time write channel
interface jcle_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [jcle_pkg::HOLD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/jcle_step.sv
// next-state and result logic for one contact sample
module jcle_step (
    input  jcle_pkg::state_t                state_in,
    input  logic [jcle_pkg::HOLD_W-1:0]     hold_time,
    input  jcle_pkg::sample_t               sample,
    output jcle_pkg::state_t                state_out,
    output jcle_pkg::result_t               result
);

    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_NONE = 8'h00;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_D    = 8'h44;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_R    = 8'h52;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_M    = 8'h4D;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_F    = 8'h46;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_O    = 8'h4F;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_E    = 8'h45;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_I    = 8'h49;
    localparam logic [jcle_pkg::CODE_W-1:0] CHAR_A    = 8'h41;

    // priority letter choice within the active group
    function automatic logic [jcle_pkg::CODE_W-1:0] pick_letter(
        input logic diag, input logic up, input logic right,
        input logic down, input logic left);
        logic [jcle_pkg::CODE_W-1:0] code;
        code = CHAR_NONE;
        if (diag)
        begin
            if (up && left)         code = CHAR_D;
            else if (up && right)   code = CHAR_R;
            else if (down && right) code = CHAR_M;
            else if (down && left)  code = CHAR_F;
        end
        else
        begin
            if (up)         code = CHAR_O;
            else if (right) code = CHAR_E;
            else if (down)  code = CHAR_I;
            else if (left)  code = CHAR_A;
        end
        return code;
    endfunction

    logic                          up;
    logic                          right;
    logic                          down;
    logic                          left;
    logic                          all_released;
    logic [jcle_pkg::HOLD_W-1:0]   limit;
    logic [jcle_pkg::HOLD_W-1:0]   count_inc;
    logic [jcle_pkg::CODE_W-1:0]   code;

    // pressed contacts are active low
    assign up           = !sample.up_released;
    assign right        = !sample.right_released;
    assign down         = !sample.down_released;
    assign left         = !sample.left_released;
    assign all_released = !up && !right && !down && !left;

    // zero hold time acts as one tick
    assign limit     = (hold_time == '0) ? jcle_pkg::HOLD_W'(1) : hold_time;
    assign count_inc = state_in.hold_count + jcle_pkg::HOLD_W'(1);
    assign code      = pick_letter(state_in.consonant_group, up, right, down, left);

    // hold timer, release and choice handling
    always_comb
    begin
        state_out           = state_in;
        result.letter_valid = 1'b0;
        result.letter_code  = CHAR_NONE;
        result.delete_last  = 1'b0;
        if (state_in.holding)
        begin
            state_out.hold_count = count_inc;
            if (count_inc >= limit)
            begin
                state_out.holding         = 1'b0;
                state_out.red_on          = 1'b0;
                state_out.green_on        = 1'b1;
                state_out.consonant_group = !state_in.consonant_group;
                state_out.finished        = 1'b1;
            end
            else if (all_released)
            begin
                state_out.holding    = 1'b0;
                state_out.red_on     = 1'b0;
                state_out.green_on   = 1'b0;
                state_out.armed      = 1'b1;
                state_out.finished   = 1'b0;
                state_out.hold_count = '0;
                result.delete_last   = 1'b1;
            end
        end
        else
        begin
            if (all_released)
            begin
                state_out.red_on     = 1'b0;
                state_out.green_on   = 1'b0;
                state_out.hold_count = '0;
                if (state_in.finished)
                begin
                    state_out.armed    = 1'b1;
                    state_out.finished = 1'b0;
                end
            end
            if (state_out.armed && (code != CHAR_NONE))
            begin
                result.letter_valid  = 1'b1;
                result.letter_code   = code;
                state_out.red_on     = 1'b1;
                state_out.green_on   = 1'b0;
                state_out.holding    = 1'b1;
                state_out.armed      = 1'b0;
                state_out.hold_count = '0;
            end
        end
        result.red_lamp   = state_out.red_on;
        result.green_lamp = state_out.green_on;
    end

endmodule

FILE: sv/joystick_chord_letter_encoder.sv
// top level of the joystick chord letter encoder
// One contact sample request is taken per clock cycle while the result channel is ready,
// and each gives exactly one result request. A sample passes an input register, one pass
// of the step logic and a result register, from which its result is presented; the
// sustained rate is one sample per cycle while the result channel is ready. The sample
// channel stalls only while a result waits in the result register and the next sample
// waits in the input register.
// The hold time register resets to 1000 and is written through the cfg channel, which
// is always ready.
module joystick_chord_letter_encoder (
    input  logic                clk,
    input  logic                rst_n,
    jcle_sample_if.sink         sample,
    jcle_result_if.source       result,
    jcle_cfg_if.sink            cfg
);

    localparam logic [jcle_pkg::HOLD_W-1:0] HOLD_TIME_RESET = 16'd1000;

    logic                          sample_valid_reg;
    jcle_pkg::sample_t             sample_reg;
    jcle_pkg::state_t              state_reg;
    jcle_pkg::state_t              state_next;
    logic [jcle_pkg::HOLD_W-1:0]   hold_time_reg;
    logic                          out_valid_reg;
    jcle_pkg::result_t             result_reg;
    jcle_pkg::result_t             result_next;
    logic                          advance;
    jcle_pkg::sample_t             sample_in;

    // stage handshakes
    assign advance      = sample_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !sample_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign sample_in.up_released    = sample.up_released;
    assign sample_in.right_released = sample.right_released;
    assign sample_in.down_released  = sample.down_released;
    assign sample_in.left_released  = sample.left_released;

    // step logic
    jcle_step u_step (
        .state_in  (state_reg),
        .hold_time (hold_time_reg),
        .sample    (sample_reg),
        .state_out (state_next),
        .result    (result_next)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg          <= 1'b0;
            out_valid_reg             <= 1'b0;
            hold_time_reg             <= HOLD_TIME_RESET;
            state_reg.consonant_group <= 1'b1;
            state_reg.armed           <= 1'b1;
            state_reg.finished        <= 1'b0;
            state_reg.holding         <= 1'b0;
            state_reg.hold_count      <= '0;
            state_reg.red_on          <= 1'b0;
            state_reg.green_on        <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                sample_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                hold_time_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            sample_reg <= sample_in;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // result channel
    assign result.valid        = out_valid_reg;
    assign result.letter_valid = result_reg.letter_valid;
    assign result.letter_code  = result_reg.letter_code;
    assign result.delete_last  = result_reg.delete_last;
    assign result.red_lamp     = result_reg.red_lamp;
    assign result.green_lamp   = result_reg.green_lamp;

endmodule

FILE: sv/jcle_checker.sv
// port checker for the joystick chord letter encoder and its bind
`include "assert_macros.svh"

module jcle_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        letter_valid,
    input logic [jcle_pkg::CODE_W-1:0] letter_code,
    input logic                        delete_last,
    input logic                        red_lamp,
    input logic                        green_lamp
);

    // a chosen letter carries a code and lights red
    `JCLE_ASSERT_IMPLY(a_letter_lights_red, clk, rst_n, out_valid && letter_valid, (letter_code != 8'h00) && red_lamp && !green_lamp)

    // no letter means a zero code
    `JCLE_ASSERT_IMPLY(a_no_letter_zero_code, clk, rst_n, out_valid && !letter_valid, letter_code == 8'h00)

    // a delete request darkens both lamps and carries no letter
    `JCLE_ASSERT_IMPLY(a_delete_dark, clk, rst_n, out_valid && delete_last, !red_lamp && !green_lamp && !letter_valid)

    // the lamps are never lit together
    `JCLE_ASSERT_IMPLY(a_lamps_exclusive, clk, rst_n, out_valid, !(red_lamp && green_lamp))

    // a stalled result request stays put
    `JCLE_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable({letter_valid, letter_code, delete_last, red_lamp, green_lamp}))

endmodule

bind joystick_chord_letter_encoder jcle_checker u_jcle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .letter_valid (result.letter_valid),
    .letter_code  (result.letter_code),
    .delete_last  (result.delete_last),
    .red_lamp     (result.red_lamp),
    .green_lamp   (result.green_lamp)
);
